// File: hw/rtl/heatmap_cell_box_decoder_assert.svh
// assertion macros shared by the box decoder rtl
`ifndef HEATMAP_CELL_BOX_DECODER_ASSERT_SVH
`define HEATMAP_CELL_BOX_DECODER_ASSERT_SVH

// condition and consequence in the same cycle
`define HCBD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/hcbd_pkg.sv
// shared types and constants for the box decoder
`default_nettype none
package hcbd_pkg;

	localparam int GRID_WIDTH  = 16;
	localparam int GRID_HEIGHT = 12;
	localparam int COL_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
	localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

	localparam int DIST_W   = 16;
	localparam int SCORE_W  = 16;
	localparam int PRODUCT_W = 2 * SCORE_W;
	localparam int ROOT_W   = PRODUCT_W / 2;
	localparam int STEP_CNT_W = $clog2(SCORE_W + 1);
	localparam int KEPT_W   = 8;
	localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};

	localparam int THR_W   = 16;
	localparam int SCALE_W = 4;
	localparam int FRAME_W = 7;
	localparam int EDGE_W  = FRAME_W + 8;
	localparam int SIZE_W  = EDGE_W + 1;

	// signed widths of cell position plus distance, and after scaling
	localparam int POS_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 8;
	localparam int SUM_W  = ((POS_W > DIST_W) ? POS_W : DIST_W) + 2;
	localparam int PROD_W = SUM_W + SCALE_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [THR_W-1:0]   THR_RESET    = THR_W'(18022);
	localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(2);
	localparam logic [FRAME_W-1:0] FWIDTH_RESET = FRAME_W'(32);
	localparam logic [FRAME_W-1:0] FHEIGHT_RESET = FRAME_W'(24);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_SCALE     = 2'd1,
		CFG_FWIDTH    = 2'd2,
		CFG_FHEIGHT   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]   min_conf;
		logic [SCALE_W-1:0] scale_factor;
		logic [FRAME_W-1:0] frame_width;
		logic [FRAME_W-1:0] frame_height;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/hcbd_serial_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module hcbd_serial_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hcbd_pkg::SCORE_W-1:0]  mcand,
	input  wire logic [hcbd_pkg::SCORE_W-1:0]  mplier,
	output logic                               done,
	output logic [hcbd_pkg::PRODUCT_W-1:0]     product
);
	import hcbd_pkg::*;

	logic [SCORE_W-1:0]    mcand_q;
	logic [PRODUCT_W-1:0]  acc_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SCORE_W:0]      sum;

	// upper half plus the multiplicand when the low bit is set
	assign sum = {1'b0, acc_q[PRODUCT_W-1:SCORE_W]}
		+ (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_CNT_W'(SCORE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= {{SCORE_W{1'b0}}, mplier};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[SCORE_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

// File: hw/rtl/hcbd_isqrt.sv
// digit-by-digit integer square root, one root bit per cycle
`default_nettype none
module hcbd_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hcbd_pkg::PRODUCT_W-1:0] radicand,
	output logic                               done,
	output logic [hcbd_pkg::ROOT_W-1:0]        root
);
	import hcbd_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [PRODUCT_W-1:0]  rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [REM_W+1:0]      rem_sh;
	logic [REM_W+1:0]      trial;
	logic                  fits;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q, rad_q[PRODUCT_W-1:PRODUCT_W-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[PRODUCT_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_sh);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// File: hw/rtl/hcbd_edge.sv
// box edge arithmetic: offset, scale, clamp to the sensor frame, extent
`default_nettype none
module hcbd_edge (
	input  wire logic                              clk,
	input  wire logic                              load,
	input  wire hcbd_pkg::cfg_t                    cfg,
	input  wire logic [hcbd_pkg::COL_W-1:0]        col,
	input  wire logic [hcbd_pkg::ROW_W-1:0]        row,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0] dist_left,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0] dist_top,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0] dist_right,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0] dist_bottom,
	output logic [hcbd_pkg::EDGE_W-1:0]            edge_left,
	output logic [hcbd_pkg::EDGE_W-1:0]            edge_top,
	output logic signed [hcbd_pkg::SIZE_W-1:0]     extent_x,
	output logic signed [hcbd_pkg::SIZE_W-1:0]     extent_y
);
	import hcbd_pkg::*;

	function automatic logic [EDGE_W-1:0] clamp_edge(
		input logic signed [PROD_W-1:0] v,
		input logic [FRAME_W-1:0]       lim
	);
		logic signed [PROD_W-1:0] hi;
		hi = PROD_W'($signed({1'b0, lim, 8'h00}));
		if (v[PROD_W-1]) begin
			clamp_edge = '0;
		end else if (v > hi) begin
			clamp_edge = {lim, 8'h00};
		end else begin
			clamp_edge = v[EDGE_W-1:0];
		end
	endfunction

	logic signed [SUM_W-1:0]  cx, cy;
	logic signed [PROD_W-1:0] scale_s;
	logic signed [PROD_W-1:0] x0, x1, y0, y1;
	logic [EDGE_W-1:0]        x0_s1, x1_s1, y0_s1, y1_s1;

	always_comb begin
		cx      = SUM_W'($signed({1'b0, col, 8'h00}));
		cy      = SUM_W'($signed({1'b0, row, 8'h00}));
		scale_s = PROD_W'($signed({1'b0, cfg.scale_factor}));
		x0 = PROD_W'(cx - SUM_W'(dist_left)) * scale_s;
		x1 = PROD_W'(cx + SUM_W'(dist_right)) * scale_s;
		y0 = PROD_W'(cy - SUM_W'(dist_top)) * scale_s;
		y1 = PROD_W'(cy + SUM_W'(dist_bottom)) * scale_s;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x0_s1 <= clamp_edge(x0, cfg.frame_width);
			x1_s1 <= clamp_edge(x1, cfg.frame_width);
			y0_s1 <= clamp_edge(y0, cfg.frame_height);
			y1_s1 <= clamp_edge(y1, cfg.frame_height);
		end
	end

	// extents may go negative for an inverted box
	always_ff @(posedge clk) begin
		extent_x <= $signed({1'b0, x1_s1}) - $signed({1'b0, x0_s1});
		extent_y <= $signed({1'b0, y1_s1}) - $signed({1'b0, y0_s1});
	end

	assign edge_left = x0_s1;
	assign edge_top  = y0_s1;

endmodule
`default_nettype wire

// File: hw/rtl/heatmap_cell_box_decoder.sv
// top level of the grid cell box decoder
// Takes one detector cell per transaction in raster order and returns one result per cell:
// a kept flag, the clamped box, its confidence, its slot among the boxes kept in the frame
// and an end-of-frame flag. Each accepted cell passes through the bit-serial score
// multiplier, then the bit-serial square root, with a hand-off between them, before the
// next cell can be accepted. The result sits in an output register,
// so the next cell is taken while the previous result still waits to be read; a finished
// cell holds in place only if that register is still full. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and should only change while no cell is in
// flight.
`default_nettype none
module heatmap_cell_box_decoder (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [hcbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [hcbd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0]  dist_left,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0]  dist_top,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0]  dist_right,
	input  wire logic signed [hcbd_pkg::DIST_W-1:0]  dist_bottom,
	input  wire logic [hcbd_pkg::SCORE_W-1:0]        class_score,
	input  wire logic [hcbd_pkg::SCORE_W-1:0]        centerness,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     box_kept,
	output logic [hcbd_pkg::EDGE_W-1:0]              box_left,
	output logic [hcbd_pkg::EDGE_W-1:0]              box_top,
	output logic signed [hcbd_pkg::SIZE_W-1:0]       box_width,
	output logic signed [hcbd_pkg::SIZE_W-1:0]       box_height,
	output logic [hcbd_pkg::ROOT_W-1:0]              box_confidence,
	output logic [hcbd_pkg::KEPT_W-1:0]              box_index,
	output logic                                     frame_last
);
	import hcbd_pkg::*;

	`include "heatmap_cell_box_decoder_assert.svh"

	state_t              state_q, state_d;
	cfg_t                cfg_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [KEPT_W-1:0]   kept_cnt_q;
	logic                kept_q;
	logic                out_valid_q;

	logic                in_fire;
	logic                out_free;
	logic                sqrt_start;
	logic                finish;
	logic                last_w;
	logic                score_done, thr_done, sqrt_done;
	logic [PRODUCT_W-1:0] score_prod, thr_prod;
	logic [ROOT_W-1:0]   root;
	logic [EDGE_W-1:0]   edge_left, edge_top;
	logic signed [SIZE_W-1:0] extent_x, extent_y;

	logic                box_kept_q;
	logic [EDGE_W-1:0]   box_left_q, box_top_q;
	logic signed [SIZE_W-1:0] box_width_q, box_height_q;
	logic [ROOT_W-1:0]   box_conf_q;
	logic [KEPT_W-1:0]   box_index_q;
	logic                frame_last_q;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign last_w   = (col_q == COL_W'(GRID_WIDTH - 1)) && (row_q == ROW_W'(GRID_HEIGHT - 1));

	hcbd_serial_mul u_score_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.mcand   (class_score),
		.mplier  (centerness),
		.done    (score_done),
		.product (score_prod)
	);

	hcbd_serial_mul u_thr_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.mcand   (cfg_q.min_conf),
		.mplier  (cfg_q.min_conf),
		.done    (thr_done),
		.product (thr_prod)
	);

	hcbd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (score_prod),
		.done     (sqrt_done),
		.root     (root)
	);

	hcbd_edge u_edge (
		.clk         (clk),
		.load        (in_fire),
		.cfg         (cfg_q),
		.col         (col_q),
		.row         (row_q),
		.dist_left   (dist_left),
		.dist_top    (dist_top),
		.dist_right  (dist_right),
		.dist_bottom (dist_bottom),
		.edge_left   (edge_left),
		.edge_top    (edge_top),
		.extent_x    (extent_x),
		.extent_y    (extent_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		sqrt_start = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (score_done && thr_done) begin
					sqrt_start = 1'b1;
					state_d    = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sqrt_done) begin
					if (out_free) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_conf     <= THR_RESET;
			cfg_q.scale_factor <= SCALE_RESET;
			cfg_q.frame_width  <= FWIDTH_RESET;
			cfg_q.frame_height <= FHEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.min_conf     <= cfg_data[THR_W-1:0];
				CFG_SCALE:     cfg_q.scale_factor <= cfg_data[SCALE_W-1:0];
				CFG_FWIDTH:    cfg_q.frame_width  <= cfg_data[FRAME_W-1:0];
				CFG_FHEIGHT:   cfg_q.frame_height <= cfg_data[FRAME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// grid position and kept count advance when a result is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			kept_cnt_q  <= '0;
			kept_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sqrt_start) begin
				kept_q <= score_prod >= thr_prod;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				if (col_q == COL_W'(GRID_WIDTH - 1)) begin
					col_q <= '0;
					if (last_w) begin
						row_q      <= '0;
						kept_cnt_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						if (kept_q && kept_cnt_q != KEPT_MAX) begin
							kept_cnt_q <= kept_cnt_q + 1'b1;
						end
					end
				end else begin
					col_q <= col_q + 1'b1;
					if (kept_q && kept_cnt_q != KEPT_MAX) begin
						kept_cnt_q <= kept_cnt_q + 1'b1;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			box_kept_q   <= kept_q;
			box_left_q   <= kept_q ? edge_left : '0;
			box_top_q    <= kept_q ? edge_top : '0;
			box_width_q  <= kept_q ? extent_x : '0;
			box_height_q <= kept_q ? extent_y : '0;
			box_conf_q   <= kept_q ? root : '0;
			box_index_q  <= kept_cnt_q;
			frame_last_q <= last_w;
		end
	end

	assign out_valid      = out_valid_q;
	assign box_kept       = box_kept_q;
	assign box_left       = box_left_q;
	assign box_top        = box_top_q;
	assign box_width      = box_width_q;
	assign box_height     = box_height_q;
	assign box_confidence = box_conf_q;
	assign box_index      = box_index_q;
	assign frame_last     = frame_last_q;

	`HCBD_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "cell accepted while one in flight")
	`HCBD_ASSERT_NEXT(a_result_follows_finish, finish, out_valid, "finished cell gave no result")
	`HCBD_ASSERT_NEXT(a_frame_end_clears, finish && last_w,
		kept_cnt_q == '0 && col_q == '0 && row_q == '0, "frame state not cleared at frame end")
	`HCBD_ASSERT_SAME(a_dropped_cell_blank, out_valid && !box_kept,
		box_confidence == '0 && box_left == '0 && box_width == '0, "dropped cell carries a box")

endmodule
`default_nettype wire
